### design/asset_name_hash_target_match_defines.svh
// assertion helpers for the asserting file
`ifndef ASSET_NAME_HASH_TARGET_MATCH_DEFINES_SVH
`define ASSET_NAME_HASH_TARGET_MATCH_DEFINES_SVH

// condition and consequence in the same cycle
`define ANHTM_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed in same-cycle check");

// consequence in the cycle after the condition
`define ANHTM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed in next-cycle check");

`endif

### design/anhtm_pkg.sv
`default_nettype none

package anhtm_pkg;

	// field widths
	localparam int OPC_W   = 2;
	localparam int CHAR_W  = 8;
	localparam int ID_W    = 32;
	localparam int SHIFT_W = 5;

	// opcodes
	localparam logic [OPC_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [OPC_W-1:0] OP_CHAR   = 2'd1;
	localparam logic [OPC_W-1:0] OP_FINISH = 2'd2;

	localparam logic [ID_W-1:0] SALT_RESET = 32'h28C0_E011;

	// target table geometry: banks spread over a row of cells
	localparam int TARGET_DEPTH = 1024;
	localparam int NCELL        = 8;
	localparam int CELL_W       = $clog2(NCELL);
	localparam int BANK_DEPTH   = (TARGET_DEPTH + NCELL - 1) / NCELL;
	localparam int BANK_AW      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int CNT_W        = $clog2(TARGET_DEPTH + 1);
	localparam int IDX_W        = BANK_AW + CELL_W;
	localparam int CMP_W        = (IDX_W > CNT_W) ? IDX_W : CNT_W;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TARGET_DEPTH);

	// word travelling along the row of cells
	typedef struct packed {
		logic               vld;
		logic               last;
		logic [BANK_AW-1:0] addr;
		logic [ID_W-1:0]    id;
		logic               hit;
	} chain_t;

	// write into one cell's bank
	typedef struct packed {
		logic               we;
		logic [BANK_AW-1:0] addr;
		logic [ID_W-1:0]    data;
	} wr_t;

	// letters 1..26 either case, digits 6..15, anything else 0
	function automatic logic [SHIFT_W-1:0] char_value(input logic [CHAR_W-1:0] ch);
		logic [CHAR_W-1:0] d;
		d = '0;
		if (ch >= 8'h61 && ch <= 8'h7A) begin
			d = ch - 8'h60;
		end else if (ch >= 8'h41 && ch <= 8'h5A) begin
			d = ch - 8'h40;
		end else if (ch >= 8'h30 && ch <= 8'h39) begin
			d = ch - 8'h2A;
		end
		return d[SHIFT_W-1:0];
	endfunction

endpackage

`default_nettype wire

### design/anhtm_cmd_if.sv
`default_nettype none

interface anhtm_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [anhtm_pkg::OPC_W-1:0]       opcode;
	logic [anhtm_pkg::CHAR_W-1:0]      char_code;
	logic [anhtm_pkg::ID_W-1:0]        target_id;

	modport source (output valid, output opcode, output char_code, output target_id,
		input ready);
	modport sink (input valid, input opcode, input char_code, input target_id,
		output ready);
endinterface

`default_nettype wire

### design/anhtm_result_if.sv
`default_nettype none

interface anhtm_result_if;
	logic                        valid;
	logic                        ready;
	logic [anhtm_pkg::ID_W-1:0]  name_id;
	logic                        hit;

	modport source (output valid, output name_id, output hit, input ready);
	modport sink (input valid, input name_id, input hit, output ready);
endinterface

`default_nettype wire

### design/anhtm_ram.sv
`default_nettype none

module anhtm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### design/anhtm_cell.sv
`default_nettype none

module anhtm_cell (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire anhtm_pkg::chain_t               up,
	input  wire anhtm_pkg::wr_t                  wr,
	input  wire logic [anhtm_pkg::CELL_W-1:0]    cell_idx,
	input  wire logic [anhtm_pkg::CNT_W-1:0]     count,
	output anhtm_pkg::chain_t                    dn
);

	logic [anhtm_pkg::ID_W-1:0] rdata;
	anhtm_pkg::chain_t          up_s1;
	logic                       in_range;
	logic                       match;

	// this cell's slice of the target table
	anhtm_ram #(
		.WIDTH (anhtm_pkg::ID_W),
		.DEPTH (anhtm_pkg::BANK_DEPTH)
	) u_bank (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (up.addr),
		.rdata (rdata)
	);

	// word is registered beside the bank read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_s1 <= '0;
		end else begin
			up_s1 <= up;
		end
	end

	// only entries below the fill count take part
	assign in_range = anhtm_pkg::CMP_W'({up_s1.addr, cell_idx}) <
		anhtm_pkg::CMP_W'(count);
	assign match = up_s1.vld && in_range && (rdata == up_s1.id);

	// fold this cell's compare into the travelling hit
	always_comb begin
		dn     = up_s1;
		dn.hit = up_s1.hit | match;
	end

endmodule

`default_nettype wire

### design/asset_name_hash_target_match.sv
// Asset-name hash with target lookup. Each command word carries an opcode: load
// stores target_id in the next free table slot (ignored when the table is full),
// char folds one character into the running name hash, finish forms
// name_id = output_salt ^ rotl(hash, 27), clears the hash and returns name_id
// with a hit flag telling whether it equals any stored target. Load and char
// words are taken one per cycle while idle. A finish sweeps the table, split over
// a row of 8 cells with one RAM bank each: the sweep issues ceil(count/8) bank
// addresses (at least one) that walk down the row one cell per cycle, the result
// word is registered once the last one leaves the row and the output is free,
// and no command is taken during the sweep. A pending result blocks commands only
// when the next sweep ends before it is taken. output_salt is written through
// cfg_we/cfg_wdata by the user only while the block is idle; it is not enforced.
`default_nettype none

module asset_name_hash_target_match (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [anhtm_pkg::ID_W-1:0]    cfg_wdata,
	anhtm_cmd_if.sink                          cmd,
	anhtm_result_if.source                     result
);

`include "asset_name_hash_target_match_defines.svh"

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]                       state_q;
	logic [anhtm_pkg::ID_W-1:0]       salt_q;
	logic [anhtm_pkg::ID_W-1:0]       hash_q;
	logic [anhtm_pkg::SHIFT_W-1:0]    shift_q;
	logic [anhtm_pkg::CNT_W-1:0]      count_q;
	logic [anhtm_pkg::ID_W-1:0]       qid_q;
	logic [anhtm_pkg::BANK_AW-1:0]    addr_q;
	logic                             issuing_q;
	logic                             acc_q;
	logic                             hold_hit_q;
	logic                             out_vld_q;
	logic [anhtm_pkg::ID_W-1:0]       out_id_q;
	logic                             out_hit_q;

	logic                             cmd_acc;
	logic [anhtm_pkg::SHIFT_W-1:0]    cval;
	logic [anhtm_pkg::SHIFT_W-1:0]    shift_nx;
	logic [anhtm_pkg::CMP_W-1:0]      cnt_x;
	logic [anhtm_pkg::CMP_W:0]        next_base;
	logic                             beat_last;
	logic                             out_free;
	logic                             out_load;
	logic                             res_hit;
	anhtm_pkg::chain_t                link [anhtm_pkg::NCELL+1];
	anhtm_pkg::wr_t                   wr   [anhtm_pkg::NCELL];
	anhtm_pkg::chain_t                tail;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;

	// character value and next shift
	assign cval     = anhtm_pkg::char_value(cmd.char_code);
	assign shift_nx = shift_q + cval;

	// sweep ends once the next bank row starts at or past the fill count
	assign cnt_x     = anhtm_pkg::CMP_W'(count_q);
	assign next_base = (anhtm_pkg::CMP_W+1)'({addr_q, {anhtm_pkg::CELL_W{1'b0}}}) +
		(anhtm_pkg::CMP_W+1)'(anhtm_pkg::NCELL);
	assign beat_last = next_base >= (anhtm_pkg::CMP_W+1)'(count_q);

	// head of the row
	always_comb begin
		link[0].vld  = issuing_q;
		link[0].last = beat_last;
		link[0].addr = addr_q;
		link[0].id   = qid_q;
		link[0].hit  = 1'b0;
	end

	// target load goes to the bank picked by the low count bits
	always_comb begin
		for (int k = 0; k < anhtm_pkg::NCELL; k++) begin
			wr[k].we   = cmd_acc && (cmd.opcode == anhtm_pkg::OP_LOAD) &&
				(count_q != anhtm_pkg::CNT_FULL) &&
				(cnt_x[anhtm_pkg::CELL_W-1:0] == anhtm_pkg::CELL_W'(k));
			wr[k].addr = cnt_x[anhtm_pkg::IDX_W-1:anhtm_pkg::CELL_W];
			wr[k].data = cmd.target_id;
		end
	end

	// row of compare cells
	for (genvar k = 0; k < anhtm_pkg::NCELL; k++) begin : g_cell
		anhtm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up       (link[k]),
			.wr       (wr[k]),
			.cell_idx (anhtm_pkg::CELL_W'(k)),
			.count    (count_q),
			.dn       (link[k+1])
		);
	end

	assign tail     = link[anhtm_pkg::NCELL];
	assign res_hit  = acc_q | tail.hit;
	assign out_free = !out_vld_q || result.ready;

	// output register takes a new word at the end of a sweep or out of hold
	assign out_load = out_free &&
		(((state_q == ST_BUSY) && tail.vld && tail.last) || (state_q == ST_HOLD));

	// salt register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			salt_q <= anhtm_pkg::SALT_RESET;
		end else if (cfg_we) begin
			salt_q <= cfg_wdata;
		end
	end

	// name hash, fill count and query id
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q  <= '0;
			shift_q <= '0;
			count_q <= '0;
			qid_q   <= '0;
		end else if (cmd_acc) begin
			case (cmd.opcode)
				anhtm_pkg::OP_LOAD: begin
					if (count_q != anhtm_pkg::CNT_FULL) begin
						count_q <= count_q + 1'b1;
					end
				end
				anhtm_pkg::OP_CHAR: begin
					if (cval != '0) begin
						shift_q <= shift_nx;
						hash_q  <= hash_q ^ (anhtm_pkg::ID_W'(1) << shift_nx);
					end
				end
				anhtm_pkg::OP_FINISH: begin
					qid_q   <= salt_q ^ {hash_q[4:0], hash_q[anhtm_pkg::ID_W-1:5]};
					hash_q  <= '0;
					shift_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// sweep sequencer and result staging
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			addr_q     <= '0;
			issuing_q  <= 1'b0;
			acc_q      <= 1'b0;
			hold_hit_q <= 1'b0;
			out_vld_q  <= 1'b0;
			out_id_q   <= '0;
			out_hit_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && result.ready) begin
				out_vld_q <= 1'b0;
			end
			if (issuing_q) begin
				if (beat_last) begin
					issuing_q <= 1'b0;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc && (cmd.opcode == anhtm_pkg::OP_FINISH)) begin
						state_q   <= ST_BUSY;
						addr_q    <= '0;
						issuing_q <= 1'b1;
						acc_q     <= 1'b0;
					end
				end
				ST_BUSY: begin
					if (tail.vld) begin
						acc_q <= res_hit;
						if (tail.last) begin
							if (out_free) begin
								out_id_q  <= qid_q;
								out_hit_q <= res_hit;
								state_q   <= ST_IDLE;
							end else begin
								hold_hit_q <= res_hit;
								state_q    <= ST_HOLD;
							end
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						out_id_q  <= qid_q;
						out_hit_q <= hold_hit_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid   = out_vld_q;
	assign result.name_id = out_id_q;
	assign result.hit     = out_hit_q;

	// checks
	`ANHTM_ASSERT_SAME(a_idle_no_issue, state_q == ST_IDLE, !issuing_q && !tail.vld)
	`ANHTM_ASSERT_SAME(a_hold_needs_full, state_q == ST_HOLD, out_vld_q)
	`ANHTM_ASSERT_NEXT(a_finish_clears, cmd_acc && (cmd.opcode == anhtm_pkg::OP_FINISH),
		(hash_q == '0) && (shift_q == '0) && (state_q == ST_BUSY) && issuing_q)
	`ANHTM_ASSERT_SAME(a_count_bound, 1'b1, count_q <= anhtm_pkg::CNT_FULL)

endmodule

`default_nettype wire
